@@ hdl/dhtv_pkg.sv @@
// Shared types and constants for the deployment hold timer and vote block.
package dhtv_pkg;

  localparam int unsigned STEP_W   = 8;
  localparam int unsigned MILLI_W  = 10;
  localparam int unsigned WDOG_W   = 7;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned HOUR_W   = 8;
  localparam int unsigned THRESH_W = 2;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 10;
  localparam int unsigned IN_DW    = 8;
  localparam int unsigned OUT_DW   = 32;

  localparam logic [SEC_W-1:0]  SECS_PER_MIN  = SEC_W'(60);
  localparam logic [MIN_W-1:0]  MINS_PER_HOUR = MIN_W'(60);
  localparam logic [HOUR_W-1:0] HOURS_MAX     = '1;

  localparam logic [STEP_W-1:0]   RST_TICK_STEP   = STEP_W'(10);
  localparam logic [MILLI_W-1:0]  RST_SEC_PERIOD  = MILLI_W'(977);
  localparam logic [WDOG_W-1:0]   RST_WDOG_PERIOD = WDOG_W'(50);
  localparam logic [MIN_W-1:0]    RST_HOLD_MINS   = MIN_W'(0);
  localparam logic [SEC_W-1:0]    RST_HOLD_SECS   = SEC_W'(10);
  localparam logic [THRESH_W-1:0] RST_VOTE_THRESH = THRESH_W'(1);

  typedef enum logic [CFG_AW-1:0] {
    REG_TICK_STEP   = 3'd0,
    REG_SEC_PERIOD  = 3'd1,
    REG_WDOG_PERIOD = 3'd2,
    REG_HOLD_MINS   = 3'd3,
    REG_HOLD_SECS   = 3'd4,
    REG_VOTE_THRESH = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  typedef struct packed {
    logic [STEP_W-1:0]   tick_step_ms;
    logic [MILLI_W-1:0]  second_period_ms;
    logic [WDOG_W-1:0]   watchdog_period_ms;
    logic [MIN_W-1:0]    hold_minutes;
    logic [SEC_W-1:0]    hold_seconds;
    logic [THRESH_W-1:0] vote_threshold;
  } cfg_t;

  typedef struct packed {
    logic [MILLI_W-1:0] milli_count;
    logic [WDOG_W-1:0]  watchdog_count;
    logic               watchdog_out;
    logic [SEC_W-1:0]   secs_count;
    logic [MIN_W-1:0]   mins_count;
    logic [HOUR_W-1:0]  hours_count;
    logic               running;
    logic               bus_state;
    logic               expired_flag;
  } state_t;

  typedef struct packed {
    op_t  operation;
    logic pin_removed;
    logic analog_timer_a;
    logic analog_timer_b;
  } item_t;

  typedef struct packed {
    logic              main_bus_on;
    logic              watchdog_level;
    logic              analog_reset_pulse;
    logic              normal_mode_request;
    logic              counting_now;
    logic              digital_expired;
    logic [1:0]        vote_count;
    logic [SEC_W-1:0]  elapsed_secs;
    logic [MIN_W-1:0]  elapsed_mins;
    logic [HOUR_W-1:0] elapsed_hours;
  } result_t;

endpackage

@@ hdl/dhtv_step.sv @@
// Next-state and result logic for one tick or poll item.
module dhtv_step import dhtv_pkg::*; (
  input  state_t  st,
  input  cfg_t    cfg,
  input  item_t   item,
  output state_t  st_nxt,
  output result_t res
);

  logic [WDOG_W+1:0]  wsum;
  logic [MILLI_W:0]   msum;
  logic [SEC_W-1:0]   secs_inc;
  logic [MIN_W-1:0]   mins_inc;
  logic               over;
  logic [1:0]         votes;
  logic [1:0]         vote_out;
  logic               pulse;
  logic               normal;

  assign wsum = {2'b00, st.watchdog_count} + {1'b0, cfg.tick_step_ms};
  assign msum = {1'b0, st.milli_count} + {{(MILLI_W-STEP_W+1){1'b0}}, cfg.tick_step_ms};
  // seconds stay below 60, so the increment never wraps
  assign secs_inc = st.secs_count + {{(SEC_W-1){1'b0}}, st.running};
  assign mins_inc = st.mins_count + {{(MIN_W-1){1'b0}}, 1'b1};

  // elapsed > hold, hours first
  always_comb begin
    if (st.hours_count != '0) begin
      over = 1'b1;
    end else if (st.mins_count != cfg.hold_minutes) begin
      over = st.mins_count > cfg.hold_minutes;
    end else begin
      over = st.secs_count > cfg.hold_seconds;
    end
  end

  assign votes = {1'b0, item.analog_timer_a} + {1'b0, item.analog_timer_b} + {1'b0, over};

  always_comb begin
    st_nxt   = st;
    pulse    = 1'b0;
    normal   = 1'b0;
    vote_out = '0;
    case (item.operation)
      OP_TICK: begin
        if (wsum >= {2'b00, cfg.watchdog_period_ms}) begin
          st_nxt.watchdog_out   = ~st.watchdog_out;
          st_nxt.watchdog_count = '0;
        end else begin
          st_nxt.watchdog_count = wsum[WDOG_W-1:0];
        end
        if (msum >= {1'b0, cfg.second_period_ms}) begin
          st_nxt.milli_count = '0;
          if (secs_inc >= SECS_PER_MIN) begin
            st_nxt.secs_count = '0;
            if (mins_inc >= MINS_PER_HOUR) begin
              st_nxt.mins_count = '0;
              if (st.hours_count != HOURS_MAX) begin
                st_nxt.hours_count = st.hours_count + {{(HOUR_W-1){1'b0}}, 1'b1};
              end
            end else begin
              st_nxt.mins_count = mins_inc;
            end
          end else begin
            st_nxt.secs_count = secs_inc;
          end
        end else begin
          st_nxt.milli_count = msum[MILLI_W-1:0];
        end
      end
      OP_POLL: begin
        if (!item.pin_removed) begin
          st_nxt.running   = 1'b0;
          st_nxt.bus_state = 1'b0;
        end else if (!st.running) begin
          st_nxt.secs_count  = '0;
          st_nxt.mins_count  = '0;
          st_nxt.hours_count = '0;
          st_nxt.running     = 1'b1;
          pulse              = 1'b1;
        end else begin
          st_nxt.expired_flag = over;
          vote_out            = votes;
          normal              = votes >= cfg.vote_threshold;
          st_nxt.bus_state    = normal;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.main_bus_on         = st_nxt.bus_state;
    res.watchdog_level      = st_nxt.watchdog_out;
    res.analog_reset_pulse  = pulse;
    res.normal_mode_request = normal;
    res.counting_now        = st_nxt.running;
    res.digital_expired     = st_nxt.expired_flag;
    res.vote_count          = vote_out;
    res.elapsed_secs        = st_nxt.secs_count;
    res.elapsed_mins        = st_nxt.mins_count;
    res.elapsed_hours       = st_nxt.hours_count;
  end

endmodule

@@ hdl/deployment_hold_timer_vote.sv @@
// Top level: post-ejection power hold timer with three-way timer vote.
//
//   channel | ports                         | carries
//   --------+-------------------------------+---------------------------------
//   in      | in_tvalid/tready/tdata/tuser  | one tick or poll item
//   out     | out_tvalid/tready/tdata       | one status item per input item
//   cfg     | cfg_wr_en/addr/wdata          | register writes, no read-back
//
// From input accept to result valid an item passes an input register, then
// the step logic feeding the result register and the timer state together.
// One item per cycle sustained while the output is not stalled; a stalled
// output holds its item while the input register still takes one more. rst_n
// is synchronous: timer state, valid flags, config registers go to defaults.
module deployment_hold_timer_vote import dhtv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [0] pin_removed, [1] analog_timer_a, [2] analog_timer_b, [7:3] zero
  input  logic [IN_DW-1:0]  in_tdata,
  // [0] operation
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [0] main_bus_on, [1] watchdog_level, [2] analog_reset_pulse,
  // [3] normal_mode_request, [4] counting_now, [5] digital_expired,
  // [7:6] vote_count, [13:8] elapsed_secs, [19:14] elapsed_mins,
  // [27:20] elapsed_hours, [31:28] zero
  output logic [OUT_DW-1:0] out_tdata,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  state_t  st_r, st_nxt;
  item_t   item_r;
  logic    item_vld_r;
  result_t res, res_r;
  logic    out_vld_r;
  logic    advance;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_step_ms       <= RST_TICK_STEP;
      cfg_r.second_period_ms   <= RST_SEC_PERIOD;
      cfg_r.watchdog_period_ms <= RST_WDOG_PERIOD;
      cfg_r.hold_minutes       <= RST_HOLD_MINS;
      cfg_r.hold_seconds       <= RST_HOLD_SECS;
      cfg_r.vote_threshold     <= RST_VOTE_THRESH;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_TICK_STEP:   cfg_r.tick_step_ms       <= cfg_wdata[STEP_W-1:0];
        REG_SEC_PERIOD:  cfg_r.second_period_ms   <= cfg_wdata[MILLI_W-1:0];
        REG_WDOG_PERIOD: cfg_r.watchdog_period_ms <= cfg_wdata[WDOG_W-1:0];
        REG_HOLD_MINS:   cfg_r.hold_minutes       <= cfg_wdata[MIN_W-1:0];
        REG_HOLD_SECS:   cfg_r.hold_seconds       <= cfg_wdata[SEC_W-1:0];
        REG_VOTE_THRESH: cfg_r.vote_threshold     <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.operation      <= op_t'(in_tuser);
      item_r.pin_removed    <= in_tdata[0];
      item_r.analog_timer_a <= in_tdata[1];
      item_r.analog_timer_b <= in_tdata[2];
    end
  end

  dhtv_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= item_vld_r;
      if (item_vld_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_vld_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000,
                       res_r.elapsed_hours,
                       res_r.elapsed_mins,
                       res_r.elapsed_secs,
                       res_r.vote_count,
                       res_r.digital_expired,
                       res_r.counting_now,
                       res_r.normal_mode_request,
                       res_r.analog_reset_pulse,
                       res_r.watchdog_level,
                       res_r.main_bus_on};

endmodule
